// ----- src/srpd_pkg.sv -----
`default_nettype none

package srpd_pkg;

	// Command codes carried on the input channel.
	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_ARM  = 2'd2;

	// Status codes of the final item of a reply.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TIMEOUT    = 3'd1;
	localparam logic [2:0] ST_BAD_HEADER = 3'd2;
	localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
	localparam logic [2:0] ST_BAD_SUM    = 3'd4;

	// Configuration register indexes.
	localparam logic REG_DEVICE_ADDRESS = 1'b0;
	localparam logic REG_TIMEOUT_TICKS  = 1'b1;

	localparam logic [31:0] DEVICE_ADDRESS_RESET = 32'hFFFF_FFFF;
	localparam logic [15:0] TIMEOUT_TICKS_RESET  = 16'd2000;

	// Frame constants.
	localparam logic [7:0]  HEADER_BYTE      = 8'hEF;
	localparam logic [7:0]  VERSION_BYTE     = 8'h01;
	localparam logic [7:0]  REPLY_PID        = 8'h07;
	localparam logic [15:0] MIN_LENGTH       = 16'd3;
	localparam logic [15:0] MAX_PACKET_BYTES = 16'd96;
	localparam logic [15:0] CHECKSUM_BYTES   = 16'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HUNT,
		PH_PREFIX,
		PH_PAYLOAD,
		PH_CK_HIGH,
		PH_CK_LOW
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_status;
		logic [2:0] status;
		logic [6:0] payload_length;
		logic       address_mismatch;
	} item_t;

endpackage

`default_nettype wire

// ----- src/sensor_reply_packet_deframer_top.sv -----
// Channel   Direction  Handshake            Beat contents
// in        input      in_valid / in_ready  command, rx_byte
// out       output     out_valid/out_ready  data_byte, is_status, status,
//                                           payload_length, address_mismatch
// cfg       input      cfg_we (no wait)     cfg_index, cfg_wdata
//
// One input beat per cycle while the output is not stalled: a beat is registered
// in the input register, processed by the parser when it leaves that register,
// and its result, if any, is then registered in the output register.
// While a result waits on out_ready the input register takes one more beat,
// then in_ready stays low until the result is taken.
// Reset returns the parser to idle and the config and valid registers to reset values.
`default_nettype none

module sensor_reply_packet_deframer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       data_byte,
	output logic             is_status,
	output logic [2:0]       status,
	output logic [6:0]       payload_length,
	output logic             address_mismatch,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	logic [31:0]     dev_addr_q;
	logic [15:0]     tmo_q;
	logic            valid_s1;
	logic [1:0]      cmd_s1;
	logic [7:0]      rx_s1;
	logic            out_valid_q;
	srpd_pkg::item_t item_q;
	srpd_pkg::item_t item;
	logic            emit;
	logic            advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= srpd_pkg::DEVICE_ADDRESS_RESET;
			tmo_q      <= srpd_pkg::TIMEOUT_TICKS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == srpd_pkg::REG_DEVICE_ADDRESS) begin
				dev_addr_q <= cfg_wdata;
			end else if (cfg_index == srpd_pkg::REG_TIMEOUT_TICKS) begin
				tmo_q <= cfg_wdata[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= command;
			rx_s1  <= rx_byte;
		end
	end

	srpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.cmd       (cmd_s1),
		.rx        (rx_s1),
		.dev_addr  (dev_addr_q),
		.tmo_ticks (tmo_q),
		.emit      (emit),
		.item      (item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			item_q <= item;
		end
	end

	assign out_valid        = out_valid_q;
	assign data_byte        = item_q.data_byte;
	assign is_status        = item_q.is_status;
	assign status           = item_q.status;
	assign payload_length   = item_q.payload_length;
	assign address_mismatch = item_q.address_mismatch;

endmodule

`default_nettype wire

// ----- src/srpd_parser.sv -----
`default_nettype none

module srpd_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [1:0]       cmd,
	input  wire logic [7:0]       rx,
	input  wire logic [31:0]      dev_addr,
	input  wire logic [15:0]      tmo_ticks,
	output logic                  emit,
	output srpd_pkg::item_t       item
);

	// Position of each byte in the prefix that follows the header.
	localparam logic [2:0] PFX_VERSION   = 3'd0;
	localparam logic [2:0] PFX_ADDR_LAST = 3'd4;
	localparam logic [2:0] PFX_PID       = 3'd5;
	localparam logic [2:0] PFX_LEN_HIGH  = 3'd6;
	localparam logic [2:0] PFX_LEN_LOW   = 3'd7;

	srpd_pkg::phase_t phase_q, phase_d;
	logic [2:0]  pfx_q, pfx_d;
	logic [23:0] addr_q, addr_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [6:0]  plen_q, plen_d;
	logic [6:0]  cnt_q, cnt_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  ck_hi_q, ck_hi_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic        bad_q, bad_d;
	logic        mism_q, mism_d;

	logic [15:0] elapsed_inc;
	logic [15:0] limit;
	logic        timed_out;
	logic [15:0] len_full;
	logic [15:0] len_minus;
	logic        len_ok;
	logic [15:0] sum_init;
	logic [6:0]  cnt_inc;
	logic        last_byte;
	logic        active;

	assign active      = (phase_q != srpd_pkg::PH_IDLE);
	assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
	assign limit       = (tmo_ticks == 16'd0) ? 16'd1 : tmo_ticks;
	assign timed_out   = (elapsed_inc >= limit);
	assign len_full    = {len_hi_q, rx};
	assign len_minus   = len_full - srpd_pkg::CHECKSUM_BYTES;
	assign len_ok      = (len_full >= srpd_pkg::MIN_LENGTH) &&
	                     (len_full <= srpd_pkg::MAX_PACKET_BYTES);
	assign sum_init    = {8'h00, srpd_pkg::REPLY_PID} + {8'h00, len_hi_q} + {8'h00, rx};
	assign cnt_inc     = cnt_q + 7'd1;
	assign last_byte   = (cnt_inc >= plen_q);

	always_comb begin
		phase_d = phase_q;
		if (step) begin
			if (cmd == srpd_pkg::CMD_ARM) begin
				phase_d = srpd_pkg::PH_HUNT;
			end else if (cmd == srpd_pkg::CMD_TICK) begin
				if (active && timed_out) begin
					phase_d = srpd_pkg::PH_IDLE;
				end
			end else if (cmd == srpd_pkg::CMD_BYTE) begin
				case (phase_q)
					srpd_pkg::PH_HUNT: begin
						if (rx == srpd_pkg::HEADER_BYTE) begin
							phase_d = srpd_pkg::PH_PREFIX;
						end
					end
					srpd_pkg::PH_PREFIX: begin
						if (pfx_q == PFX_LEN_LOW) begin
							phase_d = (bad_q || !len_ok) ? srpd_pkg::PH_IDLE
							                             : srpd_pkg::PH_PAYLOAD;
						end
					end
					srpd_pkg::PH_PAYLOAD: begin
						if (last_byte) begin
							phase_d = srpd_pkg::PH_CK_HIGH;
						end
					end
					srpd_pkg::PH_CK_HIGH: phase_d = srpd_pkg::PH_CK_LOW;
					srpd_pkg::PH_CK_LOW:  phase_d = srpd_pkg::PH_IDLE;
					default:              phase_d = srpd_pkg::PH_IDLE;
				endcase
			end
		end
	end

	always_comb begin
		emit = 1'b0;
		item = '0;
		if (step && active) begin
			if (cmd == srpd_pkg::CMD_TICK) begin
				if (timed_out) begin
					emit                  = 1'b1;
					item.is_status        = 1'b1;
					item.status           = srpd_pkg::ST_TIMEOUT;
					item.address_mismatch = mism_q;
				end
			end else if (cmd == srpd_pkg::CMD_BYTE) begin
				case (phase_q)
					srpd_pkg::PH_PREFIX: begin
						if (pfx_q == PFX_LEN_LOW && (bad_q || !len_ok)) begin
							emit                  = 1'b1;
							item.is_status        = 1'b1;
							item.status           = bad_q ? srpd_pkg::ST_BAD_HEADER
							                              : srpd_pkg::ST_BAD_LENGTH;
							item.address_mismatch = mism_q;
						end
					end
					srpd_pkg::PH_PAYLOAD: begin
						emit           = 1'b1;
						item.data_byte = rx;
					end
					srpd_pkg::PH_CK_LOW: begin
						emit                  = 1'b1;
						item.is_status        = 1'b1;
						item.address_mismatch = mism_q;
						if ({ck_hi_q, rx} == sum_q) begin
							item.status         = srpd_pkg::ST_OK;
							item.payload_length = plen_q;
						end else begin
							item.status = srpd_pkg::ST_BAD_SUM;
						end
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
		end
	end

	always_comb begin
		pfx_d     = pfx_q;
		addr_d    = addr_q;
		len_hi_d  = len_hi_q;
		plen_d    = plen_q;
		cnt_d     = cnt_q;
		sum_d     = sum_q;
		ck_hi_d   = ck_hi_q;
		elapsed_d = elapsed_q;
		bad_d     = bad_q;
		mism_d    = mism_q;
		if (step) begin
			if (cmd == srpd_pkg::CMD_ARM) begin
				pfx_d     = '0;
				addr_d    = '0;
				len_hi_d  = '0;
				plen_d    = '0;
				cnt_d     = '0;
				sum_d     = '0;
				ck_hi_d   = '0;
				elapsed_d = '0;
				bad_d     = 1'b0;
				mism_d    = 1'b0;
			end else if (active && cmd == srpd_pkg::CMD_TICK) begin
				elapsed_d = elapsed_inc;
			end else if (active && cmd == srpd_pkg::CMD_BYTE) begin
				case (phase_q)
					srpd_pkg::PH_HUNT: begin
						if (rx == srpd_pkg::HEADER_BYTE) begin
							pfx_d     = '0;
							elapsed_d = '0;
						end
					end
					srpd_pkg::PH_PREFIX: begin
						if (pfx_q != PFX_LEN_LOW) begin
							pfx_d = pfx_q + 3'd1;
						end
						if (pfx_q == PFX_VERSION) begin
							if (rx != srpd_pkg::VERSION_BYTE) begin
								bad_d = 1'b1;
							end
						end else if (pfx_q <= PFX_ADDR_LAST) begin
							// Only the three earlier address bytes need keeping; the
							// last one is compared as it arrives.
							addr_d = {addr_q[15:0], rx};
							if (pfx_q == PFX_ADDR_LAST) begin
								mism_d = ({addr_q, rx} != dev_addr);
							end
						end else if (pfx_q == PFX_PID) begin
							if (rx != srpd_pkg::REPLY_PID) begin
								bad_d = 1'b1;
							end
						end else if (pfx_q == PFX_LEN_HIGH) begin
							len_hi_d = rx;
						end else if (!bad_q && len_ok) begin
							sum_d     = sum_init;
							cnt_d     = '0;
							ck_hi_d   = '0;
							elapsed_d = '0;
							plen_d    = len_minus[6:0];
						end
					end
					srpd_pkg::PH_PAYLOAD: begin
						sum_d = sum_q + {8'h00, rx};
						cnt_d = cnt_inc;
					end
					srpd_pkg::PH_CK_HIGH: begin
						ck_hi_d = rx;
					end
					default: begin
						ck_hi_d = ck_hi_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= srpd_pkg::PH_IDLE;
			pfx_q     <= '0;
			addr_q    <= '0;
			len_hi_q  <= '0;
			plen_q    <= '0;
			cnt_q     <= '0;
			sum_q     <= '0;
			ck_hi_q   <= '0;
			elapsed_q <= '0;
			bad_q     <= 1'b0;
			mism_q    <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			pfx_q     <= pfx_d;
			addr_q    <= addr_d;
			len_hi_q  <= len_hi_d;
			plen_q    <= plen_d;
			cnt_q     <= cnt_d;
			sum_q     <= sum_d;
			ck_hi_q   <= ck_hi_d;
			elapsed_q <= elapsed_d;
			bad_q     <= bad_d;
			mism_q    <= mism_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/srpd_checker.sv -----
`default_nettype none

module srpd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  command,
	input wire logic [7:0]  rx_byte,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  data_byte,
	input wire logic        is_status,
	input wire logic [2:0]  status,
	input wire logic [6:0]  payload_length,
	input wire logic        address_mismatch,
	input wire logic        cfg_we,
	input wire logic        cfg_index,
	input wire logic [31:0] cfg_wdata
);

	// A stalled result beat must hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte) &&
		$stable(is_status) && $stable(status) && $stable(payload_length) &&
		$stable(address_mismatch))
		else $error("result beat changed while stalled");

	// The input side may only stall while a result is held back.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

	// A result appearing on an empty output comes from an input beat that passed through the input and output registers.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input beat");

	// Data beats carry no status information.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_status |-> status == 3'd0 && payload_length == 7'd0 &&
		!address_mismatch)
		else $error("status fields set on a data beat");

endmodule

bind sensor_reply_packet_deframer_top srpd_checker u_srpd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.command          (command),
	.rx_byte          (rx_byte),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.data_byte        (data_byte),
	.is_status        (is_status),
	.status           (status),
	.payload_length   (payload_length),
	.address_mismatch (address_mismatch),
	.cfg_we           (cfg_we),
	.cfg_index        (cfg_index),
	.cfg_wdata        (cfg_wdata)
);

`default_nettype wire
